[src/ring_buffer_with_average_assert.svh]
// assertion macros for the sample ring buffer
// used by the top level; needs a clock and an active-low reset name at each use
`ifndef RING_BUFFER_WITH_AVERAGE_ASSERT_SVH
`define RING_BUFFER_WITH_AVERAGE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/rbavg_pkg.sv]
// shared types, constants and helpers of the sample ring buffer
// no dependencies; imported by every module of the block
package rbavg_pkg;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int MEAN_W     = 24;
	localparam int CNT_W      = 5;
	localparam int OP_W       = 2;
	localparam int FRAC_W     = 8;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_ADDR_W = 1;

	// parameter defaults
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_OVERWRITE = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY  = 1'd1;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD  = 2'd0,
		OP_READ = 2'd1,
		OP_PEEK = 2'd2,
		OP_AVG  = 2'd3
	} op_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_SUM,
		B_DIV
	} bst_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic                overwrite;
		logic [CNT_W-1:0]    cap;
		logic                clear;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] read_value;
		logic                accepted;
		logic [MEAN_W-1:0]   mean_value;
		logic                was_empty;
		logic [CNT_W-1:0]    fill_count;
		logic                is_full;
	} res_t;

	// (a + b) mod cap for a, b below cap
	function automatic logic [CNT_W-1:0] wrap_idx(input logic [CNT_W:0] x,
	                                              input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] cap_x;
		cap_x = {1'b0, cap};
		if (x >= cap_x) begin
			wrap_idx = CNT_W'(x - cap_x);
		end else begin
			wrap_idx = CNT_W'(x);
		end
	endfunction

endpackage

[src/rbavg_front.sv]
// front end: takes requests, decodes the operation, holds them in a short queue
// depends on rbavg_pkg
module rbavg_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rbavg_pkg::OP_W-1:0]      operation,
	input  logic [rbavg_pkg::SAMPLE_W-1:0]  sample,
	output logic                            cmd_valid,
	output rbavg_pkg::cmd_t                 cmd,
	input  logic                            cmd_pop
);
	import rbavg_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	cmd_t              cmd_in;

	// operation decode
	always_comb begin
		cmd_in.sample = sample;
		unique case (operation)
			OP_ADD:  cmd_in.op = OP_ADD;
			OP_READ: cmd_in.op = OP_READ;
			OP_PEEK: cmd_in.op = OP_PEEK;
			default: cmd_in.op = OP_AVG;
		endcase
	end

	// queue handshake
	assign in_stall  = (count_q == QCNT_W'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (cmd_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

[src/rbavg_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on rbavg_pkg
module rbavg_div #(
	parameter int DIVIDEND_W = 29
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIVIDEND_W-1:0]        dividend,
	input  logic [rbavg_pkg::CNT_W-1:0]  divisor,
	output logic                         done,
	output logic [DIVIDEND_W-1:0]        quotient
);
	import rbavg_pkg::*;

	localparam int STEP_W = $clog2(DIVIDEND_W);

	logic [CNT_W-1:0]      rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      dvs_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W:0]        shifted;
	logic [CNT_W:0]        diff;
	logic                  fits;

	// one trial subtraction
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits    = (shifted >= {1'b0, dvs_q});
	assign diff    = shifted - {1'b0, dvs_q};

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(diff) : CNT_W'(shifted);
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/rbavg_back.sv]
// back end: sample storage, pointer update, average walk and result register
// depends on rbavg_pkg and rbavg_div
module rbavg_back #(
	parameter int DEPTH      = rbavg_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbavg_pkg::DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rbavg_pkg::cfg_t  cfg,
	input  logic             cmd_valid,
	input  rbavg_pkg::cmd_t  cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output rbavg_pkg::res_t  res
);
	import rbavg_pkg::*;

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = DATA_WIDTH + CNT_W;
	localparam int DIV_W  = SUM_W + FRAC_W;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	bst_t             state_q;
	bst_t             state_d;
	op_t              op_q;
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] oldest_q;
	logic [CNT_W-1:0] held_d;
	logic [CNT_W-1:0] oldest_d;
	logic [CNT_W-1:0] walk_ptr_q;
	logic [CNT_W-1:0] issue_cnt_q;
	logic             vld_s1;
	logic [SUM_W-1:0] acc_q;
	logic             out_valid_q;
	res_t             res_q;
	res_t             res_d;

	logic              out_free;
	logic              is_empty;
	logic              is_fullnow;
	logic [CNT_W-1:0]  tail;
	logic [CNT_W-1:0]  next_old;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;
	logic              walk_start;
	logic              walk_issue;
	logic              div_start;
	logic              fin;
	logic              div_done;
	logic [DIV_W-1:0]  quotient;

	// occupancy and next positions
	assign out_free   = !out_valid_q || !out_stall;
	assign is_empty   = (held_q == '0);
	assign is_fullnow = (held_q >= cfg.cap);
	assign tail       = wrap_idx({1'b0, oldest_q} + {1'b0, held_q}, cfg.cap);
	assign next_old   = wrap_idx({1'b0, oldest_q} + (CNT_W + 1)'(1), cfg.cap);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_pop && !is_empty) begin
					case (cmd.op) inside
						OP_READ, OP_PEEK: state_d = B_READ;
						OP_AVG:           state_d = B_SUM;
						default:          state_d = B_IDLE;
					endcase
				end
			end
			B_READ: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_SUM: begin
				if (div_start) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (fin) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_pop    = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = ADDR_W'(tail);
		mem_re     = 1'b0;
		mem_ra     = ADDR_W'(oldest_q);
		walk_start = 1'b0;
		walk_issue = 1'b0;
		div_start  = 1'b0;
		fin        = 1'b0;
		held_d     = held_q;
		oldest_d   = oldest_q;
		res_d      = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					res_d.was_empty = is_empty;
					case (cmd.op) inside
						OP_ADD: begin
							fin = 1'b1;
							if (!is_fullnow) begin
								mem_we   = 1'b1;
								held_d   = held_q + CNT_W'(1);
								res_d.accepted = 1'b1;
							end else if (cfg.overwrite) begin
								mem_we   = 1'b1;
								mem_wa   = ADDR_W'(oldest_q);
								oldest_d = next_old;
								res_d.accepted = 1'b1;
							end
						end
						OP_READ, OP_PEEK: begin
							if (is_empty) begin
								fin = 1'b1;
							end else begin
								mem_re = 1'b1;
							end
						end
						default: begin
							if (is_empty) begin
								fin = 1'b1;
							end else begin
								walk_start = 1'b1;
							end
						end
					endcase
				end
			end
			B_READ: begin
				if (out_free) begin
					fin = 1'b1;
					res_d.read_value = SAMPLE_W'(rdata_q);
					if (op_q == OP_READ) begin
						held_d   = held_q - CNT_W'(1);
						oldest_d = next_old;
					end
				end
			end
			B_SUM: begin
				if (issue_cnt_q != held_q) begin
					walk_issue = 1'b1;
					mem_re     = 1'b1;
					mem_ra     = ADDR_W'(walk_ptr_q);
				end else if (!vld_s1) begin
					div_start = 1'b1;
				end
			end
			B_DIV: begin
				if (div_done && out_free) begin
					fin = 1'b1;
					res_d.mean_value = MEAN_W'(quotient);
					held_d = '0;
				end
			end
			default: ;
		endcase
		res_d.fill_count = held_d;
		res_d.is_full    = (held_d >= cfg.cap);
	end

	// sample storage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= DATA_WIDTH'(cmd.sample);
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// walk and payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q <= cmd.op;
		end
		if (walk_start) begin
			walk_ptr_q  <= oldest_q;
			issue_cnt_q <= '0;
			acc_q       <= '0;
		end else begin
			if (walk_issue) begin
				walk_ptr_q  <= wrap_idx({1'b0, walk_ptr_q} + (CNT_W + 1)'(1), cfg.cap);
				issue_cnt_q <= issue_cnt_q + CNT_W'(1);
			end
			if (vld_s1) begin
				acc_q <= acc_q + SUM_W'(rdata_q);
			end
		end
		if (fin) begin
			res_q <= res_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			held_q      <= '0;
			oldest_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= walk_issue;
			if (cfg.clear) begin
				held_q   <= '0;
				oldest_q <= '0;
			end else begin
				held_q   <= held_d;
				oldest_q <= oldest_d;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// mean = (sum * 256) / count
	rbavg_div #(
		.DIVIDEND_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({acc_q, FRAC_W'(0)}),
		.divisor  (held_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

[src/ring_buffer_with_average.sv]
// top level of the sample ring buffer with average
// depends on rbavg_pkg, rbavg_front, rbavg_back and ring_buffer_with_average_assert.svh
//
//   channel   direction  transfer when            payload
//   in        to block   in_valid && !in_stall    operation, sample
//   out       from block out_valid && !out_stall  read_value .. is_full
//   cfg       to block   cfg_we                   cfg_addr, cfg_wdata
//
// add completes straight from idle, read and peek go through a registered storage read.
// average walks the storage to sum the held samples, then starts the bit-serial
// divider, which divides the scaled sum by the held count.
// a two-entry request queue takes requests, until it is full, while the back end or a
// stalled result holds; storage has no reset, held count and pointer do.
`include "ring_buffer_with_average_assert.svh"

module ring_buffer_with_average #(
	parameter int DEPTH      = rbavg_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rbavg_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rbavg_pkg::OP_W-1:0]        operation,
	input  logic [rbavg_pkg::SAMPLE_W-1:0]    sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rbavg_pkg::SAMPLE_W-1:0]    read_value,
	output logic                              accepted,
	output logic [rbavg_pkg::MEAN_W-1:0]      mean_value,
	output logic                              was_empty,
	output logic [rbavg_pkg::CNT_W-1:0]       fill_count,
	output logic                              is_full,
	input  logic                              cfg_we,
	input  logic [rbavg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [rbavg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rbavg_pkg::*;

	localparam logic [7:0]       DEPTH_CMP = 8'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(DEPTH);

	logic             overwrite_q;
	logic [CNT_W-1:0] capacity_q;
	cfg_t             cfg;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	res_t             res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overwrite_q <= 1'b0;
			capacity_q  <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_OVERWRITE: overwrite_q <= cfg_wdata[0];
				REG_CAPACITY:  capacity_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective capacity, clamped to 1..DEPTH
	always_comb begin
		cfg.overwrite = overwrite_q;
		cfg.clear     = cfg_we && (cfg_addr == REG_CAPACITY);
		if (capacity_q == '0) begin
			cfg.cap = CNT_W'(1);
		end else if (8'(capacity_q) > DEPTH_CMP) begin
			cfg.cap = DEPTH_CAP;
		end else begin
			cfg.cap = capacity_q;
		end
	end

	rbavg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sample    (sample),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rbavg_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign read_value = res.read_value;
	assign accepted   = res.accepted;
	assign mean_value = res.mean_value;
	assign was_empty  = res.was_empty;
	assign fill_count = res.fill_count;
	assign is_full    = res.is_full;

	// an average always leaves the buffer empty
	`RBA_ASSERT_NOW(a_mean_empties, clk, arst_n, out_valid && (mean_value != '0),
		fill_count == '0, "nonzero mean with entries left")
	// an empty buffer yields no data
	`RBA_ASSERT_NOW(a_empty_no_data, clk, arst_n, out_valid && was_empty,
		(read_value == '0) && (mean_value == '0), "data returned from empty buffer")
	// a stored sample leaves at least one entry
	`RBA_ASSERT_NOW(a_add_holds, clk, arst_n, out_valid && accepted,
		fill_count != '0, "accepted add with empty buffer")
	// a queued request reaches the back end once it is free
	`RBA_ASSERT_NEXT(a_queue_moves, clk, arst_n, in_stall && !out_valid && !in_valid,
		!in_stall || (u_back.state_q != B_IDLE) || out_valid, "request queue stuck")

endmodule
